// File: hdl/qsmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsmm_pkg
// Types, constants and helper functions for the quaternion/scale to model
// matrix pipeline.
// ----------------------------------------------------------------------------
package qsmm_pkg;

  localparam int QUAT_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int POS_W      = 32;
  localparam int OUT_W      = 32;
  localparam int QUAT_FRAC  = 14;
  localparam int SCALE_FRAC = 8;
  localparam int OUT_FRAC   = 16;

  localparam int PROD_W    = 2 * QUAT_W + 1;
  localparam int TERM_W    = PROD_W + 1;
  localparam int MUL_W     = TERM_W + SCALE_W;
  localparam int SHIFT     = 2 * QUAT_FRAC + SCALE_FRAC - OUT_FRAC;
  localparam int NUM_TERMS = 9;
  localparam int COLS      = 3;
  localparam int WIDE_W    = 64;

  localparam logic signed [TERM_W-1:0] ONE = TERM_W'(1) << (2 * QUAT_FRAC);
  localparam logic signed [WIDE_W-1:0] OUT_MAX = (WIDE_W'(1) << (OUT_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] OUT_MIN = -(WIDE_W'(1) << (OUT_W - 1));

  // Term slots, column major
  localparam int T_M00 = 0;
  localparam int T_M10 = 1;
  localparam int T_M20 = 2;
  localparam int T_M01 = 3;
  localparam int T_M11 = 4;
  localparam int T_M21 = 5;
  localparam int T_M02 = 6;
  localparam int T_M12 = 7;
  localparam int T_M22 = 8;

  typedef struct packed {
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [SCALE_W-1:0] scale_z;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
  } qsmm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m22;
    logic signed [POS_W-1:0] trans_x;
    logic signed [POS_W-1:0] trans_y;
    logic signed [POS_W-1:0] trans_z;
  } qsmm_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [SCALE_W-1:0] scale_z;
    pos_t                      pos;
  } side_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] wx;
    logic signed [PROD_W-1:0] wy;
    logic signed [PROD_W-1:0] wz;
    side_t                    side;
  } prod_stage_t;

  typedef struct packed {
    logic [NUM_TERMS-1:0][TERM_W-1:0] term;
    side_t                            side;
  } term_stage_t;

  typedef struct packed {
    logic [NUM_TERMS-1:0][MUL_W-1:0] mul;
    pos_t                            pos;
  } mul_stage_t;

  // 2*a*b, exact
  function automatic logic signed [PROD_W-1:0] dbl_prod(
    input logic signed [QUAT_W-1:0] a,
    input logic signed [QUAT_W-1:0] b
  );
    logic signed [2*QUAT_W-1:0] ab;
    ab = a * b;
    return {ab, 1'b0};
  endfunction

  function automatic logic signed [TERM_W-1:0] ext_prod(
    input logic signed [PROD_W-1:0] p
  );
    return {p[PROD_W-1], p};
  endfunction

  // Floor shift to Q16.16 and clamp to 32 bits
  function automatic logic signed [OUT_W-1:0] shift_sat(
    input logic signed [MUL_W-1:0] p
  );
    logic signed [WIDE_W-1:0] v;
    v = {{(WIDE_W - MUL_W){p[MUL_W-1]}}, p};
    v = v >>> SHIFT;
    if (v > OUT_MAX) begin
      return OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      return OUT_MIN[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

// File: hdl/qsmm_prod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsmm_prod
// First stage: the nine doubled quaternion cross products.
// ----------------------------------------------------------------------------
module qsmm_prod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_in,
  input  qsmm_pkg::qsmm_in_t         data_in,
  input  logic                       ready_in,
  output logic                       valid_out,
  output qsmm_pkg::prod_stage_t      data_out,
  output logic                       ready_out
);

  logic                  valid_r;
  qsmm_pkg::prod_stage_t data_r;
  qsmm_pkg::prod_stage_t data_nxt;

  assign ready_out = !valid_r || ready_in;
  assign valid_out = valid_r;
  assign data_out  = data_r;

  always_comb begin
    data_nxt.xx = qsmm_pkg::dbl_prod(data_in.quat_x, data_in.quat_x);
    data_nxt.yy = qsmm_pkg::dbl_prod(data_in.quat_y, data_in.quat_y);
    data_nxt.zz = qsmm_pkg::dbl_prod(data_in.quat_z, data_in.quat_z);
    data_nxt.xy = qsmm_pkg::dbl_prod(data_in.quat_x, data_in.quat_y);
    data_nxt.xz = qsmm_pkg::dbl_prod(data_in.quat_x, data_in.quat_z);
    data_nxt.yz = qsmm_pkg::dbl_prod(data_in.quat_y, data_in.quat_z);
    data_nxt.wx = qsmm_pkg::dbl_prod(data_in.quat_w, data_in.quat_x);
    data_nxt.wy = qsmm_pkg::dbl_prod(data_in.quat_w, data_in.quat_y);
    data_nxt.wz = qsmm_pkg::dbl_prod(data_in.quat_w, data_in.quat_z);
    data_nxt.side.scale_x   = data_in.scale_x;
    data_nxt.side.scale_y   = data_in.scale_y;
    data_nxt.side.scale_z   = data_in.scale_z;
    data_nxt.side.pos.pos_x = data_in.pos_x;
    data_nxt.side.pos.pos_y = data_in.pos_y;
    data_nxt.side.pos.pos_z = data_in.pos_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_out) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: hdl/qsmm_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsmm_term
// Second stage: rotation terms in Q6.28 from the doubled products.
// ----------------------------------------------------------------------------
module qsmm_term (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_in,
  input  qsmm_pkg::prod_stage_t      data_in,
  input  logic                       ready_in,
  output logic                       valid_out,
  output qsmm_pkg::term_stage_t      data_out,
  output logic                       ready_out
);

  logic signed [qsmm_pkg::TERM_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

  logic                  valid_r;
  qsmm_pkg::term_stage_t data_r;
  qsmm_pkg::term_stage_t data_nxt;

  assign ready_out = !valid_r || ready_in;
  assign valid_out = valid_r;
  assign data_out  = data_r;

  assign xx = qsmm_pkg::ext_prod(data_in.xx);
  assign yy = qsmm_pkg::ext_prod(data_in.yy);
  assign zz = qsmm_pkg::ext_prod(data_in.zz);
  assign xy = qsmm_pkg::ext_prod(data_in.xy);
  assign xz = qsmm_pkg::ext_prod(data_in.xz);
  assign yz = qsmm_pkg::ext_prod(data_in.yz);
  assign wx = qsmm_pkg::ext_prod(data_in.wx);
  assign wy = qsmm_pkg::ext_prod(data_in.wy);
  assign wz = qsmm_pkg::ext_prod(data_in.wz);

  always_comb begin
    data_nxt.term[qsmm_pkg::T_M00] = qsmm_pkg::ONE - (yy + zz);
    data_nxt.term[qsmm_pkg::T_M10] = xy + wz;
    data_nxt.term[qsmm_pkg::T_M20] = xz - wy;
    data_nxt.term[qsmm_pkg::T_M01] = xy - wz;
    data_nxt.term[qsmm_pkg::T_M11] = qsmm_pkg::ONE - (xx + zz);
    data_nxt.term[qsmm_pkg::T_M21] = yz + wx;
    data_nxt.term[qsmm_pkg::T_M02] = xz + wy;
    data_nxt.term[qsmm_pkg::T_M12] = yz - wx;
    data_nxt.term[qsmm_pkg::T_M22] = qsmm_pkg::ONE - (xx + yy);
    data_nxt.side = data_in.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_out) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: hdl/qsmm_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsmm_scale
// Third stage: each rotation term times its column's scale, Q14.36.
// ----------------------------------------------------------------------------
module qsmm_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_in,
  input  qsmm_pkg::term_stage_t      data_in,
  input  logic                       ready_in,
  output logic                       valid_out,
  output qsmm_pkg::mul_stage_t       data_out,
  output logic                       ready_out
);

  logic signed [qsmm_pkg::SCALE_W-1:0] scl [qsmm_pkg::COLS];
  logic [qsmm_pkg::NUM_TERMS-1:0][qsmm_pkg::MUL_W-1:0] mul_nxt;

  logic                 valid_r;
  qsmm_pkg::mul_stage_t data_r;

  assign ready_out = !valid_r || ready_in;
  assign valid_out = valid_r;
  assign data_out  = data_r;

  assign scl[0] = data_in.side.scale_x;
  assign scl[1] = data_in.side.scale_y;
  assign scl[2] = data_in.side.scale_z;

  for (genvar g = 0; g < qsmm_pkg::NUM_TERMS; g++) begin : g_mul
    logic signed [qsmm_pkg::TERM_W-1:0] tv;
    logic signed [qsmm_pkg::MUL_W-1:0]  pv;
    assign tv         = data_in.term[g];
    assign pv         = tv * scl[g / qsmm_pkg::COLS];
    assign mul_nxt[g] = pv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_out) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_r.mul <= mul_nxt;
      data_r.pos <= data_in.side.pos;
    end
  end

endmodule

// File: hdl/quaternion_scale_to_model_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_scale_to_model_matrix
// Quaternion, per-axis scale and position to the rotation-scale terms and
// translation column of an affine model matrix.
// ----------------------------------------------------------------------------
// Four register stages: doubled cross products, rotation terms, scale
// multiply, then floor shift to Q16.16 with saturation into the output
// register. One transaction enters per cycle while out_stall stays low.
// Each stage advances on its own when it is empty or its successor
// moves, so bubbles close up and in_stall rises only when all four
// stages hold data and out_stall is high.
// ----------------------------------------------------------------------------
module quaternion_scale_to_model_matrix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  qsmm_pkg::qsmm_in_t   in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output qsmm_pkg::qsmm_out_t  out_data,
  input  logic                 out_stall
);

  logic                  s1_valid, s1_ready;
  qsmm_pkg::prod_stage_t s1_data;
  logic                  s2_valid, s2_ready;
  qsmm_pkg::term_stage_t s2_data;
  logic                  s3_valid, s3_ready;
  qsmm_pkg::mul_stage_t  s3_data;

  logic                out_ready;
  logic                out_valid_r;
  qsmm_pkg::qsmm_out_t out_data_r;
  qsmm_pkg::qsmm_out_t out_data_nxt;

  qsmm_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_valid),
    .data_in   (in_data),
    .ready_in  (s2_ready),
    .valid_out (s1_valid),
    .data_out  (s1_data),
    .ready_out (s1_ready)
  );

  qsmm_term u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s1_valid),
    .data_in   (s1_data),
    .ready_in  (s3_ready),
    .valid_out (s2_valid),
    .data_out  (s2_data),
    .ready_out (s2_ready)
  );

  qsmm_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s2_valid),
    .data_in   (s2_data),
    .ready_in  (out_ready),
    .valid_out (s3_valid),
    .data_out  (s3_data),
    .ready_out (s3_ready)
  );

  assign in_stall  = !s1_ready;
  assign out_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_data_nxt.m00     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M00]);
    out_data_nxt.m10     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M10]);
    out_data_nxt.m20     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M20]);
    out_data_nxt.m01     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M01]);
    out_data_nxt.m11     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M11]);
    out_data_nxt.m21     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M21]);
    out_data_nxt.m02     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M02]);
    out_data_nxt.m12     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M12]);
    out_data_nxt.m22     = qsmm_pkg::shift_sat(s3_data.mul[qsmm_pkg::T_M22]);
    out_data_nxt.trans_x = s3_data.pos.pos_x;
    out_data_nxt.trans_y = s3_data.pos.pos_y;
    out_data_nxt.trans_z = s3_data.pos.pos_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && s2_valid && s3_valid && out_valid_r && out_stall)
  ) else $error("input stalled with a free stage in the pipeline");

  a_no_stall_when_drained: assert property (
    @(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) |-> !in_stall
  ) else $error("input stalled while the output can move");

  a_out_from_stage3: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_valid)
  ) else $error("result appeared without a filled multiply stage");

endmodule

// File: tb/tb_quaternion_scale_to_model_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_scale_to_model_matrix
// Drives quaternion, scale and position transactions into the model matrix
// pipeline and checks every result field against a predicted matrix. A
// directed table covers the extremes, the quarter and half turns, non-unit
// quaternions and the floor rounding of the shift. A random phase then
// mixes full-range, near-unit and corner-value transactions. Both channels
// idle at random except for one long stretch.
// ----------------------------------------------------------------------------
module tb_quaternion_scale_to_model_matrix;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int QUIET_FIRST  = 700;
  localparam int QUIET_LAST   = 1000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    qsmm_pkg::qsmm_in_t  stim;
    bit                  typed;
    qsmm_pkg::qsmm_out_t fixed;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  qsmm_pkg::qsmm_in_t  in_data = '0;
  logic                in_stall;
  logic                out_valid;
  qsmm_pkg::qsmm_out_t out_data;
  logic                out_stall = 1'b0;

  bit                  drv_typed = 1'b0;
  qsmm_pkg::qsmm_out_t drv_fixed = '0;
  bit                  gap_free = 1'b0;

  qsmm_pkg::qsmm_out_t matrix_q[$];
  int                  n_accepted = 0;
  int                  mismatches = 0;
  int                  cycles = 0;

  quaternion_scale_to_model_matrix uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [qsmm_pkg::OUT_W-1:0] scaled_term(longint term, longint scale);
    longint r;
    r = (term * scale) >>> 20;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return r[qsmm_pkg::OUT_W-1:0];
  endfunction

  function automatic qsmm_pkg::qsmm_out_t predict_matrix(qsmm_pkg::qsmm_in_t t);
    longint              x, y, z, w, sx, sy, sz;
    longint              xx, xy, xz, yy, yz, zz, wx, wy, wz;
    longint              unit;
    qsmm_pkg::qsmm_out_t m;
    unit = longint'(1) << 28;
    x  = t.quat_x;
    y  = t.quat_y;
    z  = t.quat_z;
    w  = t.quat_w;
    sx = t.scale_x;
    sy = t.scale_y;
    sz = t.scale_z;
    xx = 2 * x * x;
    xy = 2 * x * y;
    xz = 2 * x * z;
    yy = 2 * y * y;
    yz = 2 * y * z;
    zz = 2 * z * z;
    wx = 2 * w * x;
    wy = 2 * w * y;
    wz = 2 * w * z;
    m.m00 = scaled_term(unit - (yy + zz), sx);
    m.m10 = scaled_term(xy + wz, sx);
    m.m20 = scaled_term(xz - wy, sx);
    m.m01 = scaled_term(xy - wz, sy);
    m.m11 = scaled_term(unit - (xx + zz), sy);
    m.m21 = scaled_term(yz + wx, sy);
    m.m02 = scaled_term(xz + wy, sz);
    m.m12 = scaled_term(yz - wx, sz);
    m.m22 = scaled_term(unit - (xx + yy), sz);
    m.trans_x = t.pos_x;
    m.trans_y = t.pos_y;
    m.trans_z = t.pos_z;
    return m;
  endfunction

  function automatic qsmm_pkg::qsmm_in_t pose(int x, int y, int z, int w,
                                              int sx, int sy, int sz,
                                              int px, int py, int pz);
    qsmm_pkg::qsmm_in_t t;
    t.quat_x  = x[qsmm_pkg::QUAT_W-1:0];
    t.quat_y  = y[qsmm_pkg::QUAT_W-1:0];
    t.quat_z  = z[qsmm_pkg::QUAT_W-1:0];
    t.quat_w  = w[qsmm_pkg::QUAT_W-1:0];
    t.scale_x = sx[qsmm_pkg::SCALE_W-1:0];
    t.scale_y = sy[qsmm_pkg::SCALE_W-1:0];
    t.scale_z = sz[qsmm_pkg::SCALE_W-1:0];
    t.pos_x   = px;
    t.pos_y   = py;
    t.pos_z   = pz;
    return t;
  endfunction

  function automatic qsmm_pkg::qsmm_out_t matrix(int m00, int m10, int m20, int m01,
                                                 int m11, int m21, int m02, int m12,
                                                 int m22, int tx, int ty, int tz);
    qsmm_pkg::qsmm_out_t m;
    m = {m00, m10, m20, m01, m11, m21, m02, m12, m22, tx, ty, tz};
    return m;
  endfunction

  function automatic logic [15:0] pick16(int mode, bit is_scale);
    int corner[7];
    int v;
    corner = '{-32768, -1, 0, 1, 32767, 16384, -16384};
    if (mode == 0) begin
      v = $urandom;
    end else if (mode == 1) begin
      v = is_scale ? int'($urandom_range(1024)) - 512 : int'($urandom_range(32768)) - 16384;
    end else begin
      v = corner[$urandom_range(6)];
    end
    return v[15:0];
  endfunction

  function automatic logic [31:0] pick32(int mode);
    logic [31:0] corner[5];
    corner = '{32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1, 32'h7fff_ffff};
    return (mode == 2) ? corner[$urandom_range(4)] : 32'($urandom);
  endfunction

  task automatic check_matrix(qsmm_pkg::qsmm_out_t want, qsmm_pkg::qsmm_out_t got);
    logic [11:0][31:0] w;
    logic [11:0][31:0] g;
    string             field_name[12];
    field_name = '{"trans_z", "trans_y", "trans_x", "m22", "m12", "m02",
                   "m21", "m11", "m01", "m20", "m10", "m00"};
    w = want;
    g = got;
    for (int i = 11; i >= 0; i--) begin
      if (w[i] !== g[i]) begin
        $display("%0t: %s expected %0d actual %0d", $time, field_name[i],
                 $signed(w[i]), $signed(g[i]));
        mismatches++;
      end
    end
  endtask

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pose(qsmm_pkg::qsmm_in_t t, bit typed, qsmm_pkg::qsmm_out_t fixed);
    int seen;
    while (!gap_free && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= t;
    drv_typed <= typed;
    drv_fixed <= fixed;
    seen = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  always @(posedge clk) begin : monitor
    qsmm_pkg::qsmm_out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        matrix_q.push_back(drv_typed ? drv_fixed : predict_matrix(in_data));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = matrix_q.pop_front();
          check_matrix(want, out_data);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= !(n_accepted >= QUIET_FIRST && n_accepted < QUIET_LAST) &&
                   ($urandom_range(99) < 35);
    end
  end

  initial begin
    dir_row_t           rows[$];
    qsmm_pkg::qsmm_in_t t;
    int                 mode;
    rows.push_back('{pose(0, 0, 0, 16384, 256, 256, 256, 0, 0, 0), 1'b1,
                     matrix(65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0)});
    rows.push_back('{pose(0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678),
                     1'b1, matrix(0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678)});
    rows.push_back('{pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
                     matrix(125829120, -134217728, 0, 0, 125829120, -134217728,
                            -134217728, 0, 125829120,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000)});
    rows.push_back('{pose(0, 0, 0, -16384, -256, -256, -256, -1, 1, 0), 1'b1,
                     matrix(-65536, 0, 0, 0, -65536, 0, 0, 0, -65536, -1, 1, 0)});
    rows.push_back('{pose(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0, '0});
    rows.push_back('{pose(32767, -32768, 32767, -32768, -32768, 32767, -32768, 0, 0, 0),
                     1'b0, '0});
    rows.push_back('{pose(11585, 0, 0, 11585, 256, 256, 256, 65536, 0, 0), 1'b0, '0});
    rows.push_back('{pose(0, 11585, 0, 11585, 256, 512, 128, 0, 65536, 0), 1'b0, '0});
    rows.push_back('{pose(0, 0, 11585, 11585, 768, 256, -256, 0, 0, 65536), 1'b0, '0});
    rows.push_back('{pose(16384, 0, 0, 0, 256, 256, 256, 0, 0, 0), 1'b0, '0});
    rows.push_back('{pose(16384, 16384, 16384, 16384, 256, 256, 256, 0, 0, 0), 1'b0, '0});
    rows.push_back('{pose(32767, 100, -5000, 3, 1, -1, 300, 0, 0, 0), 1'b0, '0});
    rows.push_back('{pose(1, 0, 0, 1, -1, -1, -1, 0, 0, 0), 1'b0, '0});
    rows.push_back('{pose(-1, 1, -1, 1, 1, -1, 1, 0, 0, 0), 1'b0, '0});
    rows.push_back('{pose('h5555, 'haaaa, 'h5555, 'haaaa, 'h5555, 'haaaa, 'h5555,
                          32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555), 1'b0, '0});
    rows.push_back('{pose('haaaa, 'h5555, 'haaaa, 'h5555, 'haaaa, 'h5555, 'haaaa,
                          32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa), 1'b0, '0});
    rows.push_back('{pose(8192, -8192, 8192, 8192, 32767, -32768, 1, 0, 0, 0), 1'b0, '0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_pose(rows[i].stim, rows[i].typed, rows[i].fixed);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gap_free = (n >= QUIET_FIRST && n < QUIET_LAST);
      mode = $urandom_range(99);
      mode = (mode < 55) ? 0 : (mode < 85) ? 1 : 2;
      t.quat_x  = pick16(mode, 1'b0);
      t.quat_y  = pick16(mode, 1'b0);
      t.quat_z  = pick16(mode, 1'b0);
      t.quat_w  = pick16(mode, 1'b0);
      t.scale_x = pick16(mode, 1'b1);
      t.scale_y = pick16(mode, 1'b1);
      t.scale_z = pick16(mode, 1'b1);
      t.pos_x   = pick32(mode);
      t.pos_y   = pick32(mode);
      t.pos_z   = pick32(mode);
      send_pose(t, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (matrix_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
